// ----- hdl/q24_8_fixed_point_alu_macros.svh -----
// Assertion macros for the Q24.8 ALU checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef Q24_8_FIXED_POINT_ALU_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_MACROS_SVH

// Implication checked at every clock edge outside reset
`define QFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that holds at every clock edge outside reset
`define QFA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ----- hdl/qfa_pkg.sv -----
// Shared types, opcodes, status codes and saturation helper for the Q24.8 ALU.
// No dependencies; all files but the macro header refer to it by scoped names.
`default_nettype none

package qfa_pkg;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [3:0] {
        FN_ADD, FN_SUB, FN_MUL, FN_DIV,
        FN_GT, FN_LT, FN_GE, FN_LE,
        FN_EQ, FN_NE, FN_MIN, FN_MAX,
        FN_INC, FN_DEC, FN_TO_INT, FN_FROM_INT
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // How the back end finishes a request
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_MUL,
        KIND_DIV
    } t_kind;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result;
        logic               compare_true;
        logic [1:0]         status;
    } t_rsp;

    // Classified request: x holds |a| for mul/div, else the finished result
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [31:0] x;
        logic [31:0] mb;
        logic        cmp;
        logic [1:0]  status;
    } t_job;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
    } t_sat;

    // Signed magnitude to 32-bit two's complement, saturating
    function automatic t_sat sat_pack(input logic neg, input logic [63:0] mag);
        t_sat r;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.value = SAT_NEG;
                r.ovf   = 1'b1;
            end else begin
                r.value = 32'd0 - mag[31:0];
                r.ovf   = 1'b0;
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.value = SAT_POS;
                r.ovf   = 1'b1;
            end else begin
                r.value = mag[31:0];
                r.ovf   = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/qfa_front.sv -----
// Front end: decodes a request, finishes the simple operations and
// tags multiply and divide for the back end. Depends on qfa_pkg.
`default_nettype none

module qfa_front #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  qfa_pkg::t_req i_req,
    output qfa_pkg::t_job o_job
);

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        ua;
    logic [31:0]        ub;
    logic               na;
    logic               nb;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [31:0]        ti_mag;
    logic [63:0]        fi_mag;
    qfa_pkg::t_sat      fi_sat;

    // Split operands into sign and magnitude
    always_comb begin
        a      = i_req.operand_a;
        b      = i_req.operand_b;
        ua     = i_req.operand_a;
        ub     = i_req.operand_b;
        na     = ua[31];
        nb     = ub[31];
        ma     = na ? (32'd0 - ua) : ua;
        mb     = nb ? (32'd0 - ub) : ub;
        ti_mag = ma >> FRAC_BITS;
        fi_mag = {32'd0, ma} << FRAC_BITS;
        fi_sat = qfa_pkg::sat_pack(na, fi_mag);
    end

    // Classify and finish the simple operations
    always_comb begin
        o_job.kind   = qfa_pkg::KIND_PASS;
        o_job.neg    = na ^ nb;
        o_job.x      = 32'd0;
        o_job.mb     = mb;
        o_job.cmp    = 1'b0;
        o_job.status = qfa_pkg::ST_OK;
        unique case (qfa_pkg::t_func'(i_req.func))
            qfa_pkg::FN_ADD: o_job.x = ua + ub;
            qfa_pkg::FN_SUB: o_job.x = ua - ub;
            qfa_pkg::FN_MUL: begin
                o_job.kind = qfa_pkg::KIND_MUL;
                o_job.x    = ma;
            end
            qfa_pkg::FN_DIV: begin
                if (mb == 32'd0) begin
                    o_job.x      = na ? qfa_pkg::SAT_NEG : qfa_pkg::SAT_POS;
                    o_job.status = qfa_pkg::ST_DIVZ;
                end else begin
                    o_job.kind = qfa_pkg::KIND_DIV;
                    o_job.x    = ma;
                end
            end
            qfa_pkg::FN_GT:       o_job.cmp = (a > b);
            qfa_pkg::FN_LT:       o_job.cmp = (a < b);
            qfa_pkg::FN_GE:       o_job.cmp = (a >= b);
            qfa_pkg::FN_LE:       o_job.cmp = (a <= b);
            qfa_pkg::FN_EQ:       o_job.cmp = (a == b);
            qfa_pkg::FN_NE:       o_job.cmp = (a != b);
            qfa_pkg::FN_MIN:      o_job.x = (a <= b) ? ua : ub;
            qfa_pkg::FN_MAX:      o_job.x = (a >= b) ? ua : ub;
            qfa_pkg::FN_INC:      o_job.x = ua + 32'd1;
            qfa_pkg::FN_DEC:      o_job.x = ua - 32'd1;
            qfa_pkg::FN_TO_INT:   o_job.x = na ? (32'd0 - ti_mag) : ti_mag;
            qfa_pkg::FN_FROM_INT: begin
                o_job.x      = fi_sat.value;
                o_job.status = fi_sat.ovf ? qfa_pkg::ST_OVF : qfa_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/qfa_queue.sv -----
// Two-entry request queue between the front end and the back end.
// Depends on qfa_pkg for the queued request type.
`default_nettype none

module qfa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qfa_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output qfa_pkg::t_job o_job
);

    localparam int unsigned DEPTH = 2;

    qfa_pkg::t_job                r_mem [DEPTH];
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [$clog2(DEPTH+1)-1:0]   r_count;
    logic [$clog2(DEPTH+1)-1:0]   n_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/qfa_back.sv -----
// Back end: restoring divider pipeline (one quotient bit per stage), then
// multiply/round and saturate stages. Depends on qfa_pkg.
`default_nettype none

module qfa_back #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  qfa_pkg::t_job i_job,
    output logic          o_valid,
    output qfa_pkg::t_rsp o_rsp
);

    localparam int unsigned NUM_W = 32 + FRAC_BITS;
    localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);

    logic                 r_vld [NUM_W];
    qfa_pkg::t_job        r_job [NUM_W];
    logic [31:0]          r_rem [NUM_W];
    logic [NUM_W-1:0]     r_nq  [NUM_W];

    // Divider stages: shift one dividend bit into the remainder, subtract if it fits
    for (genvar s = 0; s < NUM_W; s++) begin : g_div
        logic              vld_in;
        qfa_pkg::t_job     job_in;
        logic [31:0]       rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [32:0]       trial;
        logic              fits;
        logic [32:0]       diff;
        logic [31:0]       n_rem;
        logic [NUM_W-1:0]  n_nq;

        if (s == 0) begin : g_head
            assign vld_in = i_valid;
            assign job_in = i_job;
            assign rem_in = 32'd0;
            assign nq_in  = {i_job.x, {FRAC_BITS{1'b0}}};
        end else begin : g_chain
            assign vld_in = r_vld[s-1];
            assign job_in = r_job[s-1];
            assign rem_in = r_rem[s-1];
            assign nq_in  = r_nq[s-1];
        end

        always_comb begin
            trial = {rem_in, nq_in[NUM_W-1]};
            fits  = (trial >= {1'b0, job_in.mb});
            diff  = trial - {1'b0, job_in.mb};
            n_rem = fits ? diff[31:0] : trial[31:0];
            n_nq  = {nq_in[NUM_W-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_job[s] <= job_in;
            r_rem[s] <= n_rem;
            r_nq[s]  <= n_nq;
        end
    end

    // Product or rounded quotient
    logic                 r_e1_vld;
    qfa_pkg::t_job        r_e1_job;
    logic [63:0]          r_e1_mag;
    logic [63:0]          n_e1_mag;
    logic [63:0]          prod;
    logic                 rnd_up;
    logic [63:0]          quot;
    qfa_pkg::t_job        last_job;

    always_comb begin
        last_job = r_job[NUM_W-1];
        prod     = {32'd0, last_job.x} * {32'd0, last_job.mb};
        rnd_up   = ({r_rem[NUM_W-1], 1'b0} >= {1'b0, last_job.mb});
        quot     = {{(64-NUM_W){1'b0}}, r_nq[NUM_W-1]} + {63'd0, rnd_up};
        n_e1_mag = (last_job.kind == qfa_pkg::KIND_MUL) ? prod : quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= r_vld[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_job <= last_job;
        r_e1_mag <= n_e1_mag;
    end

    // Round the product, saturate and form the response
    logic                 r_valid;
    qfa_pkg::t_rsp        r_rsp;
    qfa_pkg::t_rsp        n_rsp;
    logic [63:0]          mag;
    qfa_pkg::t_sat        sat;

    always_comb begin
        if (r_e1_job.kind == qfa_pkg::KIND_MUL) begin
            mag = (r_e1_mag + HALF) >> FRAC_BITS;
        end else begin
            mag = r_e1_mag;
        end
        sat = qfa_pkg::sat_pack(r_e1_job.neg, mag);
        if (r_e1_job.kind == qfa_pkg::KIND_PASS) begin
            n_rsp.result       = r_e1_job.x;
            n_rsp.compare_true = r_e1_job.cmp;
            n_rsp.status       = r_e1_job.status;
        end else begin
            n_rsp.result       = sat.value;
            n_rsp.compare_true = 1'b0;
            n_rsp.status       = sat.ovf ? qfa_pkg::ST_OVF : qfa_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_e1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ----- hdl/q24_8_fixed_point_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU: front end, request queue, back end.
// Depends on qfa_pkg, qfa_front, qfa_queue and qfa_back.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   request   | start / busy       | i_req : func, operand_a, operand_b
//   response  | o_valid (strobe)   | o_rsp : result, compare_true, status
//
// Outside reset one request enters per clock; the queue never fills.
// The latency is set by the divider pipeline, one quotient bit per stage over
// 32 + FRAC_BITS stages, plus the queue, product and saturation stages.
// Every operation takes the same path, so responses leave in request order.
// Reset is synchronous and active low; busy stays high while it is asserted.
// The response strobe cannot be stalled; the queue drains every cycle.
`default_nettype none

module q24_8_fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  qfa_pkg::t_req i_req,
    output logic          o_valid,
    output qfa_pkg::t_rsp o_rsp
);

    qfa_pkg::t_job front_job;
    qfa_pkg::t_job head_job;
    logic          head_valid;
    logic          q_full;
    logic          accept;

    assign busy   = q_full || !i_rst_n;
    assign accept = start && !busy;

    // Decode and classify
    qfa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_req (i_req),
        .o_job (front_job)
    );

    // Hold classified requests until the back end takes them
    qfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (head_valid),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // Execute multiply and divide, finish every response
    qfa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ----- hdl/qfa_checker.sv -----
// Port-level checker for the Q24.8 ALU and its bind to the top level.
// Depends on qfa_pkg and q24_8_fixed_point_alu_macros.svh.
`default_nettype none
`include "q24_8_fixed_point_alu_macros.svh"

module qfa_checker #(
    parameter int unsigned FRAC_BITS = 8
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire qfa_pkg::t_req i_req,
    input wire logic          o_valid,
    input wire qfa_pkg::t_rsp o_rsp
);

    localparam int unsigned LAT = FRAC_BITS + 35;

    logic req_cmp;
    logic req_div_zero;
    logic req_take;
    logic rsp_clean;
    logic rsp_divz;

    // Classify requests and responses at the ports
    always_comb begin
        req_take     = start && !busy;
        req_cmp      = (i_req.func == qfa_pkg::FN_GT) || (i_req.func == qfa_pkg::FN_LT) ||
                       (i_req.func == qfa_pkg::FN_GE) || (i_req.func == qfa_pkg::FN_LE) ||
                       (i_req.func == qfa_pkg::FN_EQ) || (i_req.func == qfa_pkg::FN_NE);
        req_div_zero = (i_req.func == qfa_pkg::FN_DIV) && (i_req.operand_b == 32'sd0);
        rsp_clean    = (o_rsp.result == 32'sd0) && (o_rsp.status == qfa_pkg::ST_OK);
        rsp_divz     = o_valid && (o_rsp.status == qfa_pkg::ST_DIVZ);
    end

    `QFA_ASSERT_IMP(a_never_busy, $past(i_rst_n), !busy, "request refused outside reset")
    `QFA_ASSERT_IMP(a_rsp_has_req, o_valid, $past(req_take, LAT), "response without request")
    `QFA_ASSERT_IMP(a_cmp_clean, o_valid && $past(req_cmp, LAT), rsp_clean, "comparison not clean")
    `QFA_ASSERT_IMP(a_flag_only_cmp, o_valid && !$past(req_cmp, LAT), !o_rsp.compare_true, "stray flag")
    `QFA_ASSERT_IMP(a_divz_source, rsp_divz, $past(req_div_zero, LAT), "stray divide-by-zero")

endmodule

bind q24_8_fixed_point_alu qfa_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_qfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corner cases, then random requests.
// Depends on qfa_pkg and q24_8_fixed_point_alu; predicts every response and checks it in order.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned FRAC_BITS   = 8;
    localparam int          LATENCY     = FRAC_BITS + 35;
    localparam int          RANDOM_REQS = 600;
    localparam int          CYCLE_LIMIT = 200000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    qfa_pkg::t_req i_req;
    logic          o_valid;
    qfa_pkg::t_rsp o_rsp;

    // busy as the block sees it at the next rising edge
    logic busy_q;

    qfa_pkg::t_rsp expected_rsp_q[$];
    int   err_count;
    int   req_count;
    int   rsp_count;
    int   sat_count;
    int   divz_count;
    int   cycles;
    int   idle_max;

    q24_8_fixed_point_alu #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Clamp a signed magnitude to 32 bits; bit 32 flags saturation
    function automatic logic [32:0] saturate_q(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        logic        ovf;
        m   = mag;
        ovf = 1'b0;
        if (neg && m > 64'h8000_0000) begin
            m   = 64'h8000_0000;
            ovf = 1'b1;
        end else if (!neg && m > 64'h7FFF_FFFF) begin
            m   = 64'h7FFF_FFFF;
            ovf = 1'b1;
        end
        return {ovf, neg ? (32'd0 - m[31:0]) : m[31:0]};
    endfunction

    // Compute the response the ALU owes for one request
    function automatic qfa_pkg::t_rsp alu_response(input qfa_pkg::t_req r);
        qfa_pkg::t_rsp rsp;
        logic [31:0] ra;
        logic [31:0] rb;
        logic        na;
        logic        nb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] prod;
        logic [63:0] quo;
        logic [32:0] sat;
        ra   = r.operand_a;
        rb   = r.operand_b;
        na   = ra[31];
        nb   = rb[31];
        ma   = na ? (64'h1_0000_0000 - {32'd0, ra}) : {32'd0, ra};
        mb   = nb ? (64'h1_0000_0000 - {32'd0, rb}) : {32'd0, rb};
        sat  = '0;
        rsp  = '0;
        case (r.func)
            qfa_pkg::FN_ADD: rsp.result = ra + rb;
            qfa_pkg::FN_SUB: rsp.result = ra - rb;
            qfa_pkg::FN_MUL: begin
                prod = ma * mb;
                quo  = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                sat  = saturate_q(na ^ nb, quo);
                rsp.result = sat[31:0];
            end
            qfa_pkg::FN_DIV: begin
                if (mb == 64'd0) begin
                    rsp.result = na ? qfa_pkg::SAT_NEG : qfa_pkg::SAT_POS;
                    rsp.status = qfa_pkg::ST_DIVZ;
                end else begin
                    quo = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    sat = saturate_q(na ^ nb, quo);
                    rsp.result = sat[31:0];
                end
            end
            qfa_pkg::FN_GT: rsp.compare_true = $signed(ra) >  $signed(rb);
            qfa_pkg::FN_LT: rsp.compare_true = $signed(ra) <  $signed(rb);
            qfa_pkg::FN_GE: rsp.compare_true = $signed(ra) >= $signed(rb);
            qfa_pkg::FN_LE: rsp.compare_true = $signed(ra) <= $signed(rb);
            qfa_pkg::FN_EQ: rsp.compare_true = ra == rb;
            qfa_pkg::FN_NE: rsp.compare_true = ra != rb;
            qfa_pkg::FN_MIN: rsp.result = ($signed(ra) <= $signed(rb)) ? ra : rb;
            qfa_pkg::FN_MAX: rsp.result = ($signed(ra) >= $signed(rb)) ? ra : rb;
            qfa_pkg::FN_INC: rsp.result = ra + 32'd1;
            qfa_pkg::FN_DEC: rsp.result = ra - 32'd1;
            qfa_pkg::FN_TO_INT: begin
                sat = saturate_q(na, ma >> FRAC_BITS);
                rsp.result = sat[31:0];
            end
            default: begin
                sat = saturate_q(na, ma << FRAC_BITS);
                rsp.result = sat[31:0];
            end
        endcase
        if (sat[32])
            rsp.status = qfa_pkg::ST_OVF;
        return rsp;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, exp_v, got_v);
        err_count++;
    endtask

    // Idle for a random gap, then hold one request until the block takes it
    task automatic send_req(input qfa_pkg::t_req r);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy_q);
    endtask

    task automatic send_op(input qfa_pkg::t_func f, input logic [31:0] a,
                           input logic [31:0] b);
        qfa_pkg::t_req r;
        r.func      = f;
        r.operand_a = a;
        r.operand_b = b;
        send_req(r);
    endtask

    // Pick an operand: full range, small values or extremes
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = $urandom;
            3:       v = 32'($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
            4:       v = 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
            default: begin
                case ($urandom_range(0, 7))
                    0: v = qfa_pkg::SAT_POS;
                    1: v = qfa_pkg::SAT_NEG;
                    2: v = 32'd0;
                    3: v = 32'd1;
                    4: v = 32'hFFFF_FFFF;
                    5: v = 32'd256;
                    6: v = 32'hFFFF_FF00;
                    default: v = 32'h0080_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // Wrapping arithmetic, rounding and saturation of mul and div, and divide by zero
    task automatic test_arith_corners();
        send_op(qfa_pkg::FN_ADD, qfa_pkg::SAT_POS, 32'd1);
        send_op(qfa_pkg::FN_SUB, qfa_pkg::SAT_NEG, 32'd1);
        send_op(qfa_pkg::FN_MUL, qfa_pkg::SAT_POS, qfa_pkg::SAT_POS);
        send_op(qfa_pkg::FN_MUL, 32'd1, 32'd128);
        send_op(qfa_pkg::FN_MUL, 32'hFFFF_FFFF, 32'd128);
        send_op(qfa_pkg::FN_MUL, qfa_pkg::SAT_NEG, 32'd256);
        send_op(qfa_pkg::FN_DIV, 32'd256, 32'd0);
        send_op(qfa_pkg::FN_DIV, 32'hFFFF_FF00, 32'd0);
        send_op(qfa_pkg::FN_DIV, qfa_pkg::SAT_POS, 32'd1);
        send_op(qfa_pkg::FN_DIV, 32'd256, 32'd768);
    endtask

    // Comparisons, min and max at the extremes and with ties
    task automatic test_compare_ops();
        send_op(qfa_pkg::FN_GT, qfa_pkg::SAT_NEG, qfa_pkg::SAT_POS);
        send_op(qfa_pkg::FN_LT, qfa_pkg::SAT_NEG, qfa_pkg::SAT_POS);
        send_op(qfa_pkg::FN_GE, 32'h1234_5678, 32'h1234_5678);
        send_op(qfa_pkg::FN_LE, qfa_pkg::SAT_POS, qfa_pkg::SAT_NEG);
        send_op(qfa_pkg::FN_EQ, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
        send_op(qfa_pkg::FN_NE, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
        send_op(qfa_pkg::FN_MIN, 32'h0000_0300, 32'h0000_0300);
        send_op(qfa_pkg::FN_MAX, qfa_pkg::SAT_NEG, qfa_pkg::SAT_POS);
    endtask

    // Increment, decrement and the integer conversions
    task automatic test_unary_ops();
        send_op(qfa_pkg::FN_INC, qfa_pkg::SAT_POS, 32'hA5A5_A5A5);
        send_op(qfa_pkg::FN_DEC, qfa_pkg::SAT_NEG, 32'h5A5A_5A5A);
        send_op(qfa_pkg::FN_TO_INT, 32'hFFFF_FE80, 32'd0);
        send_op(qfa_pkg::FN_TO_INT, qfa_pkg::SAT_NEG, 32'd0);
        send_op(qfa_pkg::FN_FROM_INT, 32'h0080_0000, 32'd0);
        send_op(qfa_pkg::FN_FROM_INT, qfa_pkg::SAT_NEG, 32'd0);
        send_op(qfa_pkg::FN_FROM_INT, 32'hFF80_0000, 32'd0);
    endtask

    // Random requests in blocks, alternating idle gaps with back-to-back streams
    task automatic test_random_ops();
        qfa_pkg::t_req r;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 100 == 0)
                idle_max = ((i / 100) % 2 == 0) ? 14 : 0;
            r.func      = 4'($urandom_range(0, 15));
            r.operand_a = rand_operand();
            r.operand_b = ($urandom_range(0, 7) == 0) ? r.operand_a : rand_operand();
            send_req(r);
        end
        idle_max = 14;
    endtask

    // Track what the block sees on busy
    always @(negedge i_clk) begin
        busy_q <= busy;
    end

    // Record the expected response for every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy_q) begin
            expected_rsp_q.push_back(alu_response(i_req));
            req_count++;
        end
    end

    // Check each response against the oldest expectation
    always @(posedge i_clk) begin
        qfa_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("unexpected response", 32'd0, o_rsp.result);
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                rsp_count++;
                if (exp_rsp.status == qfa_pkg::ST_OVF)
                    sat_count++;
                if (exp_rsp.status == qfa_pkg::ST_DIVZ)
                    divz_count++;
                if (o_rsp.result !== exp_rsp.result)
                    report_mismatch("result", exp_rsp.result, o_rsp.result);
                if (o_rsp.compare_true !== exp_rsp.compare_true)
                    report_mismatch("compare_true", 32'(exp_rsp.compare_true),
                                    32'(o_rsp.compare_true));
                if (o_rsp.status !== exp_rsp.status)
                    report_mismatch("status", 32'(exp_rsp.status), 32'(o_rsp.status));
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycles, expected_rsp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        err_count  = 0;
        req_count  = 0;
        rsp_count  = 0;
        sat_count  = 0;
        divz_count = 0;
        cycles     = 0;
        idle_max   = 14;
        busy_q     = 1'b1;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_req     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        @(posedge i_clk);

        test_arith_corners();
        test_compare_ops();
        test_unary_ops();
        test_random_ops();

        // Drop start and drain the pipeline
        start <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d requests over all 16 opcodes; checked %0d responses", req_count,
                 rsp_count);
        $display("Saturated responses: %0d, divide-by-zero responses: %0d", sat_count,
                 divz_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
